// ----- src/gpm_pkg.sv -----
// gf2_poly_mul_mod package: default width, reset modulus, cell control struct
// and controller state codes. Depends on nothing.
`default_nettype none

package gpm_pkg;

   localparam int POLY_WIDTH_DEFAULT = 14;
   localparam int MODULUS_RESET      = 19;

   // control broadcast from the controller to every cell
   typedef struct packed {
      logic clear;
      logic step;
      logic load_a;
      logic add_en;
      logic fb;
   } gpm_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_REDA = 3'b010,
      ST_MULB = 3'b100
   } gpm_state_type;

endpackage

`default_nettype wire

// ----- src/gpm_req_if.sv -----
// request channel: valid/ready with the two operand polynomials.
// Depends on gpm_pkg.
`default_nettype none

interface gpm_req_if #(
   parameter int POLY_WIDTH = gpm_pkg::POLY_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [POLY_WIDTH-1:0] operand_a;
   logic [POLY_WIDTH-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

// ----- src/gpm_rsp_if.sv -----
// response channel: valid/ready with the reduced product.
// Depends on gpm_pkg.
`default_nettype none

interface gpm_rsp_if #(
   parameter int POLY_WIDTH = gpm_pkg::POLY_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [POLY_WIDTH-2:0] remainder;

   modport source (output valid, output remainder, input ready);
   modport sink   (input valid, input remainder, output ready);
endinterface

`default_nettype wire

// ----- src/gpm_csr_if.sv -----
// configuration write channel: valid/ready with the modulus polynomial.
// Depends on gpm_pkg.
`default_nettype none

interface gpm_csr_if #(
   parameter int POLY_WIDTH = gpm_pkg::POLY_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [POLY_WIDTH-1:0] modulus_poly;

   modport source (output valid, output modulus_poly, input ready);
   modport sink   (input valid, input modulus_poly, output ready);
endinterface

`default_nettype wire

// ----- src/gf2_poly_mul_mod.sv -----
// gf2_poly_mul_mod top level: controller, modulus register and the cell row.
// Depends on gpm_pkg, gpm_req_if, gpm_rsp_if, gpm_csr_if and gpm_cell.
//
// For each item the row of POLY_WIDTH-1 remainder cells first
// shifts operand_a in most significant bit first, one coefficient a cycle,
// leaving a mod m, then runs Horner steps over operand_b, one bit a cycle,
// with one conditional subtraction of the modulus per step. The result lands
// in an output register, so a new item is taken while it waits; the row
// holds its last step only if the previous result has not been taken yet.
// modulus_poly resets to x^4+x+1 and must be written only while idle; a
// zero modulus returns 0 and a degree-zero modulus returns 0.
`default_nettype none

module gf2_poly_mul_mod #(
   parameter int POLY_WIDTH = gpm_pkg::POLY_WIDTH_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   gpm_req_if.sink   req_chan,
   gpm_rsp_if.source rsp_chan,
   gpm_csr_if.sink   csr_chan
);

   localparam int CW = $clog2(POLY_WIDTH);
   localparam int RW = POLY_WIDTH - 1;

   gpm_pkg::gpm_state_type state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [POLY_WIDTH-1:0]  a_sh_ff, a_sh_in;
   logic [POLY_WIDTH-1:0]  b_sh_ff, b_sh_in;
   logic [POLY_WIDTH-1:0]  modulus_ff, modulus_in;
   logic [POLY_WIDTH-1:0]  top_ff, top_in;
   logic                   mzero_ff, mzero_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]          remainder_ff, remainder_in;

   gpm_pkg::gpm_ctrl_type  ctrl;
   logic [RW-1:0]          r_q;
   logic [RW-1:0]          r_nx;
   logic [RW-1:0]          shift_vec;
   logic                   in_bit;
   logic                   out_free;
   logic                   req_acc;
   logic                   csr_acc;
   logic                   last;
   logic [POLY_WIDTH-1:0]  mod_src;
   logic [POLY_WIDTH-1:0]  fb_terms;

   assign req_acc  = req_chan.valid & req_chan.ready;
   assign csr_acc  = csr_chan.valid & csr_chan.ready;
   assign out_free = ~rsp_valid_ff | rsp_chan.ready;
   assign last     = (cnt_ff == '0);

   assign req_chan.ready  = (state_ff == gpm_pkg::ST_IDLE);
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.remainder = remainder_ff;

   // modulus and one-hot mark of its leading coefficient
   always_comb begin
      mod_src = reset ? POLY_WIDTH'(gpm_pkg::MODULUS_RESET) : csr_chan.modulus_poly;
      for (int j = 0; j < POLY_WIDTH; j++) begin
         top_in[j] = mod_src[j] & ~(|(mod_src >> (j + 1)));
      end
      modulus_in = mod_src;
      mzero_in   = ~(|mod_src);
   end

   always_ff @(posedge clock) begin
      if (reset || csr_acc) begin
         modulus_ff <= modulus_in;
         top_ff     <= top_in;
         mzero_ff   <= mzero_in;
      end
   end

   // feedback: coefficient at the modulus degree after the shift
   assign in_bit = (state_ff == gpm_pkg::ST_REDA) ? a_sh_ff[POLY_WIDTH-1] : 1'b0;

   always_comb begin
      shift_vec[0] = in_bit;
      for (int i = 1; i < RW; i++) begin
         shift_vec[i] = r_q[i-1];
      end
      fb_terms[0] = top_ff[0] & in_bit;
      for (int j = 1; j < POLY_WIDTH; j++) begin
         fb_terms[j] = top_ff[j] & r_q[j-1];
      end
   end

   always_comb begin
      ctrl.clear  = req_acc;
      ctrl.step   = (state_ff == gpm_pkg::ST_REDA) ||
                    ((state_ff == gpm_pkg::ST_MULB) && (!last || out_free));
      ctrl.load_a = (state_ff == gpm_pkg::ST_REDA) && last;
      ctrl.add_en = (state_ff == gpm_pkg::ST_MULB) && b_sh_ff[POLY_WIDTH-1];
      ctrl.fb     = |fb_terms;
   end

   for (genvar i = 0; i < RW; i++) begin : g_cell
      gpm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .shift_in (shift_vec[i]),
         .m_bit    (modulus_ff[i]),
         .r_out    (r_q[i]),
         .r_next   (r_nx[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      a_sh_in      = a_sh_ff;
      b_sh_in      = b_sh_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      remainder_in = remainder_ff;
      unique case (state_ff)
         gpm_pkg::ST_IDLE: begin
            if (req_acc) begin
               a_sh_in  = req_chan.operand_a;
               b_sh_in  = req_chan.operand_b;
               cnt_in   = CW'(POLY_WIDTH - 1);
               state_in = gpm_pkg::ST_REDA;
            end
         end
         gpm_pkg::ST_REDA: begin
            a_sh_in = a_sh_ff << 1;
            if (last) begin
               cnt_in   = CW'(POLY_WIDTH - 1);
               state_in = gpm_pkg::ST_MULB;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         gpm_pkg::ST_MULB: begin
            if (!last) begin
               b_sh_in = b_sh_ff << 1;
               cnt_in  = cnt_ff - 1'b1;
            end else if (out_free) begin
               remainder_in = mzero_ff ? '0 : r_nx;
               rsp_valid_in = 1'b1;
               state_in     = gpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gpm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_sh_ff      <= a_sh_in;
      b_sh_ff      <= b_sh_in;
      remainder_ff <= remainder_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == gpm_pkg::ST_REDA) && (cnt_ff == CW'(POLY_WIDTH - 1)))
      else $error("accepted item did not start operand reduction");

   a_reda_to_mulb: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gpm_pkg::ST_REDA) && last) |=>
      (state_ff == gpm_pkg::ST_MULB) && (cnt_ff == CW'(POLY_WIDTH - 1)))
      else $error("operand reduction did not hand over to multiply phase");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
      $past(state_ff == gpm_pkg::ST_MULB) && $past(last) && (state_ff == gpm_pkg::ST_IDLE))
      else $error("result appeared without a finished multiply phase");

endmodule

`default_nettype wire

// ----- src/gpm_cell.sv -----
// one remainder cell: holds one coefficient of the running remainder and of
// the reduced first operand. Depends on gpm_pkg.
`default_nettype none

module gpm_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  gpm_pkg::gpm_ctrl_type ctrl,
   input  wire                   shift_in,
   input  wire                   m_bit,
   output logic                  r_out,
   output logic                  r_next
);

   logic r_ff, r_in;
   logic a_ff, a_in;

   always_comb begin
      r_next = shift_in ^ (ctrl.fb & m_bit) ^ (ctrl.add_en & a_ff);
      r_in   = r_ff;
      a_in   = a_ff;
      if (ctrl.clear) begin
         r_in = 1'b0;
      end else if (ctrl.step) begin
         if (ctrl.load_a) begin
            a_in = r_next;
            r_in = 1'b0;
         end else begin
            r_in = r_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= 1'b0;
      end else begin
         r_ff <= r_in;
      end
      a_ff <= a_in;
   end

   assign r_out = r_ff;

endmodule

`default_nettype wire

// ----- tb/sv/gf2_poly_mul_mod_tb.sv -----
// testbench for gf2_poly_mul_mod: drives operand pairs and modulus writes over
// the valid/ready channels and checks every remainder against a predictor.
// Depends on gpm_pkg, gpm_req_if, gpm_rsp_if, gpm_csr_if and gf2_poly_mul_mod.
`default_nettype none

module gf2_poly_mul_mod_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW             = gpm_pkg::POLY_WIDTH_DEFAULT;
   localparam int NUM_PHASES     = 12;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int NUM_DIRECTED   = 18;

   localparam logic [PW-1:0] DIR_A [NUM_DIRECTED] = '{
      14'h0000, 14'h0000, 14'h3fff, 14'h3fff, 14'h0001, 14'h0001,
      14'h2000, 14'h2000, 14'h2aaa, 14'h1555, 14'h0013, 14'h0013,
      14'h0026, 14'h000f, 14'h0010, 14'h0008, 14'h3ffe, 14'h1fff
   };
   localparam logic [PW-1:0] DIR_B [NUM_DIRECTED] = '{
      14'h0000, 14'h3fff, 14'h0000, 14'h3fff, 14'h0001, 14'h2000,
      14'h0001, 14'h2000, 14'h1555, 14'h2aaa, 14'h0001, 14'h3fff,
      14'h0005, 14'h000f, 14'h0001, 14'h0002, 14'h2001, 14'h1000
   };

   class remainder_scoreboard;
      logic [PW-1:0] modulus = PW'(gpm_pkg::MODULUS_RESET);
      logic [PW-2:0] expected_q [$];
      int            mismatches = 0;
      int            compared   = 0;
      int            accepted   = 0;
      int            settings   = 1;

      function automatic logic [PW-2:0] predicted_remainder(logic [PW-1:0] a,
                                                           logic [PW-1:0] b,
                                                           logic [PW-1:0] m);
         logic [2*PW-2:0] prod;
         int              mdeg;
         prod = '0;
         mdeg = -1;
         for (int i = 0; i < PW; i++) begin
            if (b[i]) prod ^= (2*PW-1)'(a) << i;
            if (m[i]) mdeg = i;
         end
         if (mdeg < 0) return '0;
         for (int d = 2*PW-2; d >= mdeg; d--) begin
            if (prod[d]) prod ^= (2*PW-1)'(m) << (d - mdeg);
         end
         return prod[PW-2:0];
      endfunction

      function void set_modulus(logic [PW-1:0] m);
         modulus = m;
         settings++;
      endfunction

      function void note_operands(logic [PW-1:0] a, logic [PW-1:0] b);
         expected_q.push_back(predicted_remainder(a, b, modulus));
         accepted++;
      endfunction

      function void check_remainder(logic [PW-2:0] actual);
         logic [PW-2:0] expected;
         if (expected_q.size() == 0) begin
            $display("%0t: remainder %h arrived with no item outstanding", $time, actual);
            mismatches++;
            return;
         end
         expected = expected_q.pop_front();
         compared++;
         if (actual !== expected) begin
            $display("%0t: remainder expected %h actual %h", $time, expected, actual);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   no_gaps;
   bit   hold_request;
   int   cycle_count;

   remainder_scoreboard board = new();

   gpm_req_if #(.POLY_WIDTH(PW)) req_bus ();
   gpm_rsp_if #(.POLY_WIDTH(PW)) rsp_bus ();
   gpm_csr_if #(.POLY_WIDTH(PW)) csr_bus ();

   gf2_poly_mul_mod #(.POLY_WIDTH(PW)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_operands(req_bus.operand_a, req_bus.operand_b);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_remainder(rsp_bus.remainder);
         if (csr_bus.valid && csr_bus.ready)
            board.set_modulus(csr_bus.modulus_poly);
      end
   end

   // result side, with one long hold-off to back up the block
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = no_gaps ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   function automatic logic [PW-1:0] random_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return PW'(1) << $urandom_range(0, PW-1);
         3: return ~(PW'(1) << $urandom_range(0, PW-1));
         4: return PW'($urandom_range(0, 31));
         5: return board.modulus;
         default: return PW'($urandom_range(0, (1 << PW) - 1));
      endcase
   endfunction

   function automatic logic [PW-1:0] modulus_for_phase(int ph);
      case (ph)
         1: return PW'(1);
         2: return '0;
         3: return '1;
         4: return PW'(1) << (PW-1);
         5: return 14'h201b;
         6: return 14'h011b;
         7: return PW'(3);
         8: return PW'(2);
         11: return PW'(gpm_pkg::MODULUS_RESET);
         default: return PW'($urandom_range(1, (1 << PW) - 1));
      endcase
   endfunction

   task automatic send_operands(input logic [PW-1:0] a, input logic [PW-1:0] b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [PW-1:0] m);
      wait_for_drain();
      repeat (4) @(posedge clock);
      csr_bus.valid        <= 1'b1;
      csr_bus.modulus_poly <= m;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      no_gaps               = 1'b0;
      hold_request          = 1'b0;
      req_bus.valid        <= 1'b0;
      req_bus.operand_a    <= '0;
      req_bus.operand_b    <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.modulus_poly <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_operands(DIR_A[i], DIR_B[i]);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) write_modulus(modulus_for_phase(ph));
         no_gaps = (ph % 4 == 3);
         if (ph == 2) hold_request = 1'b1;
         repeat (ITEMS_PER_PHASE) send_operands(random_operand(), random_operand());
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d operand pairs under %0d modulus settings, %0d remainders compared",
               board.accepted, board.settings, board.compared);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d remainders missing", board.mismatches,
                  board.pending());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- gf2_poly_mul_mod.f -----
src/gpm_pkg.sv
src/gpm_req_if.sv
src/gpm_rsp_if.sv
src/gpm_csr_if.sv
src/gpm_cell.sv
src/gf2_poly_mul_mod.sv
tb/sv/gf2_poly_mul_mod_tb.sv
